@@ hw/rtl/gcpsu_pkg.sv @@
`timescale 1ns / 1ps

package gcpsu_pkg;

	// fraction bits of the phase outputs
	localparam int PHASE_FRAC_BITS = 16;
	localparam int CORDIC_STEPS    = 30;
	localparam int PRE_SHIFT       = 30;
	localparam int GRAY_BITS       = 7;

	// CORDIC vector datapath: 9-bit difference scaled by 2^30, gain ~1.65
	localparam int XY_W  = 42;
	// angle accumulator, 2^-32 turn units
	localparam int Z_W   = 35;
	// rounded angle before the wrap fix, signed
	localparam int RND_W = Z_W - 32 + PHASE_FRAC_BITS;
	// wrapped phase, (0, one turn]
	localparam int WR_W  = PHASE_FRAC_BITS + 1;
	// absolute phase before trimming to the port width
	localparam int UNW_W = PHASE_FRAC_BITS + 9;

	typedef logic signed [XY_W-1:0]  xy_t;
	typedef logic signed [Z_W-1:0]   zang_t;
	typedef logic signed [RND_W-1:0] rnd_t;
	typedef logic [WR_W-1:0]         wr_t;
	typedef logic signed [UNW_W-1:0] unw_t;
	typedef logic signed [7:0]       offset_t;

	localparam wr_t  ONE_TURN     = wr_t'(1) << PHASE_FRAC_BITS;
	localparam wr_t  QUARTER_TURN = wr_t'(1) << (PHASE_FRAC_BITS - 2);
	localparam wr_t  THREE_QUARTER = ONE_TURN - QUARTER_TURN;
	localparam rnd_t RND_ONE_TURN = rnd_t'(1) << PHASE_FRAC_BITS;
	localparam zang_t Z_HALF      = zang_t'(1) << 31;
	localparam zang_t Z_QUARTER   = zang_t'(1) << 30;
	localparam zang_t Z_RND_BIAS  = zang_t'(1) << (31 - PHASE_FRAC_BITS);

	typedef struct packed {
		logic [7:0] white_level;
		logic [7:0] gray_sample_0;
		logic [7:0] gray_sample_1;
		logic [7:0] gray_sample_2;
		logic [7:0] gray_sample_3;
		logic [7:0] gray_sample_4;
		logic [7:0] gray_sample_5;
		logic [7:0] gray_sample_6;
		logic [7:0] shift_sample_0;
		logic [7:0] shift_sample_1;
		logic [7:0] shift_sample_2;
		logic [7:0] shift_sample_3;
	} pixel_t;

	typedef struct packed {
		logic signed [23:0] unwrapped_phase;
		logic [16:0]        wrapped_phase;
		logic [6:0]         period_index;
	} phase_t;

	// one beat inside the CORDIC chain
	typedef struct packed {
		xy_t        x;
		xy_t        y;
		zang_t      z;
		logic       bypass;   // axis or zero vector, angle already exact
		logic [5:0] k1;
		logic [6:0] k2;
	} cordic_t;

	// atan(2^-i) in 2^-32 turn units
	function automatic zang_t turn_tab(input logic [4:0] idx);
		zang_t r;
		case (idx)
			5'd0:  r = zang_t'(64'h20000000);
			5'd1:  r = zang_t'(64'h12E4051E);
			5'd2:  r = zang_t'(64'h09FB385B);
			5'd3:  r = zang_t'(64'h051111D4);
			5'd4:  r = zang_t'(64'h028B0D43);
			5'd5:  r = zang_t'(64'h0145D7E1);
			5'd6:  r = zang_t'(64'h00A2F61E);
			5'd7:  r = zang_t'(64'h00517C55);
			5'd8:  r = zang_t'(64'h0028BE53);
			5'd9:  r = zang_t'(64'h00145F2F);
			5'd10: r = zang_t'(64'h000A2F98);
			5'd11: r = zang_t'(64'h000517CC);
			5'd12: r = zang_t'(64'h00028BE6);
			5'd13: r = zang_t'(64'h000145F3);
			5'd14: r = zang_t'(64'h0000A2FA);
			5'd15: r = zang_t'(64'h0000517D);
			5'd16: r = zang_t'(64'h000028BE);
			5'd17: r = zang_t'(64'h0000145F);
			5'd18: r = zang_t'(64'h00000A30);
			5'd19: r = zang_t'(64'h00000518);
			5'd20: r = zang_t'(64'h0000028C);
			5'd21: r = zang_t'(64'h00000146);
			5'd22: r = zang_t'(64'h000000A3);
			5'd23: r = zang_t'(64'h00000051);
			5'd24: r = zang_t'(64'h00000029);
			5'd25: r = zang_t'(64'h00000014);
			5'd26: r = zang_t'(64'h0000000A);
			5'd27: r = zang_t'(64'h00000005);
			5'd28: r = zang_t'(64'h00000003);
			5'd29: r = zang_t'(64'h00000001);
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

@@ hw/rtl/gcpsu_cordic.sv @@
`timescale 1ns / 1ps

// Vectoring CORDIC, one micro-rotation per register stage.
module gcpsu_cordic (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  gcpsu_pkg::cordic_t  in_beat,
	output logic                out_valid,
	input  logic                out_ready,
	output gcpsu_pkg::cordic_t  out_beat
);

	logic               v_s   [gcpsu_pkg::CORDIC_STEPS];
	logic               rdy   [gcpsu_pkg::CORDIC_STEPS];
	gcpsu_pkg::cordic_t d_s   [gcpsu_pkg::CORDIC_STEPS];
	gcpsu_pkg::cordic_t nxt   [gcpsu_pkg::CORDIC_STEPS];

	for (genvar i = 0; i < gcpsu_pkg::CORDIC_STEPS; i++) begin : g_step
		logic               up_v;
		logic               dn_rdy;
		gcpsu_pkg::cordic_t cur;
		gcpsu_pkg::xy_t     xs;
		gcpsu_pkg::xy_t     ys;

		if (i == 0) begin : g_first
			assign up_v = in_valid;
			assign cur  = in_beat;
		end else begin : g_mid
			assign up_v = v_s[i-1];
			assign cur  = d_s[i-1];
		end

		if (i == gcpsu_pkg::CORDIC_STEPS - 1) begin : g_last
			assign dn_rdy = out_ready;
		end else begin : g_inner
			assign dn_rdy = rdy[i+1];
		end

		assign rdy[i] = !v_s[i] || dn_rdy;
		assign xs = cur.x >>> i;
		assign ys = cur.y >>> i;

		always_comb begin
			nxt[i] = cur;
			if (!cur.bypass) begin
				if (!cur.y[gcpsu_pkg::XY_W-1]) begin
					nxt[i].x = cur.x + ys;
					nxt[i].y = cur.y - xs;
					nxt[i].z = cur.z + gcpsu_pkg::turn_tab(5'(i));
				end else begin
					nxt[i].x = cur.x - ys;
					nxt[i].y = cur.y + xs;
					nxt[i].z = cur.z - gcpsu_pkg::turn_tab(5'(i));
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i] <= 1'b0;
			end else if (rdy[i]) begin
				v_s[i] <= up_v;
			end
		end

		always_ff @(posedge clk) begin
			if (rdy[i] && up_v) begin
				d_s[i] <= nxt[i];
			end
		end
	end

	assign in_ready  = rdy[0];
	assign out_valid = v_s[gcpsu_pkg::CORDIC_STEPS-1];
	assign out_beat  = d_s[gcpsu_pkg::CORDIC_STEPS-1];

endmodule

@@ hw/rtl/gray_code_phase_shift_unwrap.sv @@
`timescale 1ns / 1ps

// Gray-code plus four-step phase-shift unwrapping, one camera pixel per beat.
//
// pix channel (pix_valid/pix_ready/pix): white level, seven Gray pattern
// samples and four phase-shift samples of one pixel.
// phase channel (phase_valid/phase_ready/phase): absolute phase, wrapped
// phase in (0, one turn] and fringe order k2, one result beat per pixel.
//
// Throughput: one pixel per clock, sustained while phase_ready stays high.
// There are 33 register stages and the first one loads at the accepting
// edge: 1 prepare stage, 30 CORDIC micro-rotation stages, 1 rounding stage,
// 1 offset/output stage.
//
// Every stage carries its own valid bit and loads when it is empty or its
// successor moves, so bubbles collapse and a stalled receiver backs the
// pipeline up one stage at a time; pix_ready drops only when all 33 stages
// hold beats. Nothing is lost or repeated under stall.
//
// Reset (arst_n low) empties the pipeline: all valid bits clear, no beat in
// flight survives. No configuration, no state between pixels.
module gray_code_phase_shift_unwrap (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              pix_valid,
	output logic              pix_ready,
	input  gcpsu_pkg::pixel_t pix,
	output logic              phase_valid,
	input  logic              phase_ready,
	output gcpsu_pkg::phase_t phase
);

	// ---------------------------------------------------------------
	// stage 1: binarize, Gray decode, vector setup
	// ---------------------------------------------------------------
	logic               v_s1;
	logic               rdy_s1;
	gcpsu_pkg::cordic_t cd_s1;
	gcpsu_pkg::cordic_t prep;

	logic               cd_in_ready;
	logic               cd_out_valid;
	gcpsu_pkg::cordic_t cd_out;

	logic [7:0]         thr;
	logic [6:0]         g7;
	logic [6:0]         b7;
	logic [7:0]         b7_inc;
	logic signed [8:0]  dx;
	logic signed [8:0]  dy;
	logic signed [8:0]  px;
	logic signed [8:0]  py;

	assign thr = {1'b0, pix.white_level[7:1]};

	// sample 0 is the code MSB
	assign g7 = {pix.gray_sample_0 > thr, pix.gray_sample_1 > thr,
		pix.gray_sample_2 > thr, pix.gray_sample_3 > thr,
		pix.gray_sample_4 > thr, pix.gray_sample_5 > thr,
		pix.gray_sample_6 > thr};

	always_comb begin
		b7[6] = g7[6];
		for (int i = 5; i >= 0; i--) begin
			b7[i] = b7[i+1] ^ g7[i];
		end
	end

	// k2 = (bin7 + 1) >> 1; k1 is the decoded 6-bit code, i.e. bin7 >> 1
	assign b7_inc = {1'b0, b7} + 8'd1;

	assign dx = $signed({1'b0, pix.shift_sample_0}) - $signed({1'b0, pix.shift_sample_2});
	assign dy = $signed({1'b0, pix.shift_sample_3}) - $signed({1'b0, pix.shift_sample_1});

	always_comb begin
		px          = dx;
		py          = dy;
		prep.z      = '0;
		prep.bypass = 1'b0;
		if (dy == 9'sd0) begin
			// on the x axis, or zero vector: zero or half a turn
			prep.bypass = 1'b1;
			prep.z      = dx[8] ? gcpsu_pkg::Z_HALF : '0;
		end else if (dx == 9'sd0) begin
			prep.bypass = 1'b1;
			prep.z      = dy[8] ? -gcpsu_pkg::Z_QUARTER : gcpsu_pkg::Z_QUARTER;
		end else if (dx[8]) begin
			// left half-plane: rotate by half a turn first
			px     = -dx;
			py     = -dy;
			prep.z = gcpsu_pkg::Z_HALF;
		end
		prep.x  = gcpsu_pkg::xy_t'(px) <<< gcpsu_pkg::PRE_SHIFT;
		prep.y  = gcpsu_pkg::xy_t'(py) <<< gcpsu_pkg::PRE_SHIFT;
		prep.k1 = b7[6:1];
		prep.k2 = b7_inc[7:1];
	end

	assign rdy_s1    = !v_s1 || cd_in_ready;
	assign pix_ready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (rdy_s1) begin
			v_s1 <= pix_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && pix_valid) begin
			cd_s1 <= prep;
		end
	end

	// ---------------------------------------------------------------
	// CORDIC chain
	// ---------------------------------------------------------------
	logic v_s2;
	logic rdy_s2;

	gcpsu_cordic u_cordic (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s1),
		.in_ready  (cd_in_ready),
		.in_beat   (cd_s1),
		.out_valid (cd_out_valid),
		.out_ready (rdy_s2),
		.out_beat  (cd_out)
	);

	// ---------------------------------------------------------------
	// stage 2: round to PHASE_FRAC_BITS, fold into (0, one turn]
	// ---------------------------------------------------------------
	gcpsu_pkg::zang_t z_rnd;
	gcpsu_pkg::rnd_t  w_rnd;
	gcpsu_pkg::rnd_t  w_fix;
	gcpsu_pkg::wr_t   wrapped_s2;
	logic [5:0]       k1_s2;
	logic [6:0]       k2_s2;
	logic             v_s3;
	logic             rdy_s3;

	assign z_rnd = cd_out.z + gcpsu_pkg::Z_RND_BIAS;
	assign w_rnd = z_rnd[gcpsu_pkg::Z_W-1 -: gcpsu_pkg::RND_W];
	assign w_fix = (w_rnd <= 0) ? w_rnd + gcpsu_pkg::RND_ONE_TURN : w_rnd;

	assign rdy_s2 = !v_s2 || rdy_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (rdy_s2) begin
			v_s2 <= cd_out_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s2 && cd_out_valid) begin
			wrapped_s2 <= w_fix[gcpsu_pkg::WR_W-1:0];
			k1_s2      <= cd_out.k1;
			k2_s2      <= cd_out.k2;
		end
	end

	// ---------------------------------------------------------------
	// stage 3: fringe order by quarter-turn thresholds, output register
	// ---------------------------------------------------------------
	gcpsu_pkg::offset_t offset;
	gcpsu_pkg::unw_t    unw;
	gcpsu_pkg::phase_t  phase_d;
	gcpsu_pkg::phase_t  phase_s3;

	always_comb begin
		if (wrapped_s2 < gcpsu_pkg::QUARTER_TURN) begin
			offset = $signed({1'b0, k2_s2});
		end else if (wrapped_s2 < gcpsu_pkg::THREE_QUARTER) begin
			offset = $signed({2'b00, k1_s2});
		end else begin
			// may go to -1 at the left edge
			offset = $signed({1'b0, k2_s2}) - 8'sd1;
		end
		unw = gcpsu_pkg::unw_t'($signed({1'b0, wrapped_s2}))
			+ (gcpsu_pkg::unw_t'(offset) <<< gcpsu_pkg::PHASE_FRAC_BITS);
		phase_d.unwrapped_phase = 24'(unw);
		phase_d.wrapped_phase   = 17'(wrapped_s2);
		phase_d.period_index    = k2_s2;
	end

	assign rdy_s3 = !v_s3 || phase_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (rdy_s3) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s3 && v_s2) begin
			phase_s3 <= phase_d;
		end
	end

	assign phase_valid = v_s3;
	assign phase       = phase_s3;

endmodule

@@ sim/phase_checker.sv @@
`timescale 1ns / 1ps

// Watches both channels, predicts the phase of every accepted pixel and
// compares it with the result beats in order.
module phase_checker (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              pix_valid,
	input  logic              pix_ready,
	input  gcpsu_pkg::pixel_t pix,
	input  logic              phase_valid,
	input  logic              phase_ready,
	input  gcpsu_pkg::phase_t phase,
	output int                mismatch_count,
	output int                phases_owed
);
	import gcpsu_pkg::*;

	// atan(2^-i) in 2^-32 turn units
	longint rot_angle [0:29] = '{
		64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
		64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
		64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
		64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
		64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051, 64'h00000029,
		64'h00000014, 64'h0000000A, 64'h00000005, 64'h00000003, 64'h00000001
	};

	phase_t expected_phases [$];
	phase_t want;

	initial begin
		mismatch_count = 0;
		phases_owed    = 0;
	end

	// angle of (re, im) in 2^-32 turns, vectoring CORDIC
	function automatic longint angle_of(input longint re, input longint im);
		longint acc;
		longint re_sh;
		longint im_sh;
		int     i;
		acc = 0;
		if (im == 0)
			return (re < 0) ? (longint'(1) <<< 31) : 0;
		if (re == 0)
			return (im > 0) ? (longint'(1) <<< 30) : -(longint'(1) <<< 30);
		if (re < 0) begin
			re  = -re;
			im  = -im;
			acc = longint'(1) <<< 31;
		end
		re = re <<< 30;
		im = im <<< 30;
		for (i = 0; i < 30; i++) begin
			re_sh = re >>> i;
			im_sh = im >>> i;
			if (im >= 0) begin
				re  = re + im_sh;
				im  = im - re_sh;
				acc = acc + rot_angle[i];
			end else begin
				re  = re - im_sh;
				im  = im + re_sh;
				acc = acc - rot_angle[i];
			end
		end
		return acc;
	endfunction

	function automatic phase_t predict_phase(input pixel_t p);
		phase_t     r;
		logic [7:0] thr;
		logic [6:0] code7;
		logic [6:0] bin7;
		logic [7:0] k2;
		longint     ang;
		longint     wr;
		longint     offs;
		longint     unw;
		longint     turn;
		longint     quarter;
		int         i;
		thr   = p.white_level >> 1;
		code7 = {p.gray_sample_0 > thr, p.gray_sample_1 > thr, p.gray_sample_2 > thr,
			p.gray_sample_3 > thr, p.gray_sample_4 > thr, p.gray_sample_5 > thr,
			p.gray_sample_6 > thr};
		// prefix XOR from the MSB; the 6-bit code decodes to bin7[6:1]
		bin7[6] = code7[6];
		for (i = 5; i >= 0; i--)
			bin7[i] = bin7[i+1] ^ code7[i];
		k2 = ({1'b0, bin7} + 8'd1) >> 1;

		ang     = angle_of(longint'(p.shift_sample_0) - longint'(p.shift_sample_2),
			longint'(p.shift_sample_3) - longint'(p.shift_sample_1));
		turn    = longint'(1) <<< PHASE_FRAC_BITS;
		quarter = longint'(1) <<< (PHASE_FRAC_BITS - 2);
		wr      = (ang + (longint'(1) <<< (31 - PHASE_FRAC_BITS))) >>> (32 - PHASE_FRAC_BITS);
		if (wr <= 0)
			wr = wr + turn;

		if (wr < quarter)
			offs = longint'(k2);
		else if (wr < 3 * quarter)
			offs = longint'(bin7[6:1]);
		else
			offs = longint'(k2) - 1;
		unw = wr + offs * turn;

		r.unwrapped_phase = unw[23:0];
		r.wrapped_phase   = wr[16:0];
		r.period_index    = k2[6:0];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_phases.delete();
			phases_owed <= 0;
		end else begin
			if (phase_valid && phase_ready) begin
				if (expected_phases.size() == 0) begin
					$error("phase beat with no pixel outstanding");
					mismatch_count++;
				end else begin
					want = expected_phases.pop_front();
					if (phase.unwrapped_phase !== want.unwrapped_phase) begin
						$error("unwrapped_phase: expected %0d, got %0d",
							$signed(want.unwrapped_phase), $signed(phase.unwrapped_phase));
						mismatch_count++;
					end
					if (phase.wrapped_phase !== want.wrapped_phase) begin
						$error("wrapped_phase: expected %0d, got %0d",
							want.wrapped_phase, phase.wrapped_phase);
						mismatch_count++;
					end
					if (phase.period_index !== want.period_index) begin
						$error("period_index: expected %0d, got %0d",
							want.period_index, phase.period_index);
						mismatch_count++;
					end
				end
			end
			if (pix_valid && pix_ready)
				expected_phases.push_back(predict_phase(pix));
			phases_owed <= expected_phases.size();
		end
	end

endmodule

@@ sim/gray_code_phase_shift_unwrap_tb.sv @@
`timescale 1ns / 1ps

module gray_code_phase_shift_unwrap_tb;
	import gcpsu_pkg::*;

	// random pixels per idling mode; four modes give ~1350 pixels
	localparam int MODE_BEATS = 338;
	// pipeline depth is 33, leave some slack after the last result
	localparam int TAIL_CYCLES = 40;

	// gray sample placement relative to the threshold
	localparam int LVL_ANY  = 0;
	localparam int LVL_NEAR = 1;
	localparam int LVL_FAR  = 2;

	logic   clk         = 1'b0;
	logic   arst_n      = 1'b0;
	logic   pix_valid   = 1'b0;
	pixel_t pix         = '0;
	logic   phase_ready = 1'b0;
	logic   pix_ready;
	logic   phase_valid;
	phase_t phase;

	int mismatch_count;
	int phases_owed;

	// percent of cycles the pixel source idles / the phase sink stalls
	int src_gap_pct  = 0;
	int sink_hold_pct = 0;

	initial begin
		forever #2 clk = ~clk;
	end

	// watchdog: a correct run needs only a small fraction of this
	initial begin
		#2000000;
		$display("gray_code_phase_shift_unwrap test failed");
		$finish;
	end

	gray_code_phase_shift_unwrap i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.pix_valid   (pix_valid),
		.pix_ready   (pix_ready),
		.pix         (pix),
		.phase_valid (phase_valid),
		.phase_ready (phase_ready),
		.phase       (phase)
	);

	phase_checker i_phase_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.pix_valid      (pix_valid),
		.pix_ready      (pix_ready),
		.pix            (pix),
		.phase_valid    (phase_valid),
		.phase_ready    (phase_ready),
		.phase          (phase),
		.mismatch_count (mismatch_count),
		.phases_owed    (phases_owed)
	);

	// phase sink: redraws ready every cycle, so stalls land on any pipeline phase
	initial begin
		forever begin
			@(posedge clk);
			phase_ready <= ($urandom_range(99) >= sink_hold_pct);
		end
	end

	// Builds a pixel whose binarized gray code equals code (bit 6 = sample 0).
	// lvl picks how far each sample sits from the threshold: anywhere on its
	// side, right at the edge (thr vs thr+1), or at the rail (0 vs 255).
	function automatic pixel_t make_pixel(input logic [7:0] white, input logic [6:0] code,
		input logic [7:0] s0, input logic [7:0] s1, input logic [7:0] s2,
		input logic [7:0] s3, input int lvl);
		pixel_t     p;
		int         thr;
		int         i;
		logic [7:0] v;
		thr = int'(white >> 1);
		p.white_level = white;
		for (i = 0; i < 7; i++) begin
			if (code[6-i]) begin
				case (lvl)
					LVL_NEAR: v = 8'(thr + 1);
					LVL_FAR:  v = 8'd255;
					default:  v = 8'($urandom_range(255, thr + 1));
				endcase
			end else begin
				case (lvl)
					LVL_NEAR: v = 8'(thr);
					LVL_FAR:  v = 8'd0;
					default:  v = 8'($urandom_range(thr, 0));
				endcase
			end
			// gray samples sit right below white_level in the packed struct
			p[87 - 8*i -: 8] = v;
		end
		p.shift_sample_0 = s0;
		p.shift_sample_1 = s1;
		p.shift_sample_2 = s2;
		p.shift_sample_3 = s3;
		return p;
	endfunction

	// Mostly structured pixels with a chosen code and a shaped fringe vector,
	// the rest raw noise. Axis and near-axis vectors land on the exact-angle
	// paths and on the quarter-turn offset thresholds.
	function automatic pixel_t random_pixel();
		logic [7:0] a;
		logic [7:0] b;
		logic [7:0] c;
		logic [7:0] d;
		if ($urandom_range(9) < 3)
			return pixel_t'({$urandom(), $urandom(), $urandom()});
		a = 8'($urandom());
		b = 8'($urandom());
		c = 8'($urandom());
		d = 8'($urandom());
		case ($urandom_range(9))
			0: c = a;                                  // x = 0
			1: d = b;                                  // y = 0
			2: c = (a == 8'd0) ? 8'd1 : a - 8'd1;      // |x| = 1
			3: d = (b == 8'd255) ? 8'd254 : b + 8'd1;  // |y| = 1
			4: begin                                   // tiny vector
				a = 8'($urandom_range(131, 125));
				b = 8'($urandom_range(131, 125));
				c = 8'($urandom_range(131, 125));
				d = 8'($urandom_range(131, 125));
			end
			default: ;
		endcase
		return make_pixel(8'($urandom()), 7'($urandom()), a, b, c, d, $urandom_range(2));
	endfunction

	// One beat on the pix channel. Valid is only dropped during a gap, so
	// back-to-back beats keep it high without a glitch.
	task automatic send_pixel(input pixel_t p);
		while ($urandom_range(99) < src_gap_pct) begin
			pix_valid <= 1'b0;
			@(posedge clk);
		end
		pix       <= p;
		pix_valid <= 1'b1;
		do
			@(posedge clk);
		while (!pix_ready);
	endtask

	// hold the source off until every predicted phase has come back
	task automatic drain();
		pix_valid <= 1'b0;
		@(posedge clk);
		while (phases_owed != 0)
			@(posedge clk);
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed corners, no idling.
		// zero vector everywhere: wrapped = one turn, offset k2-1 = -1
		send_pixel('0);
		send_pixel('1);
		// samples right at the binarization edge, both rails of white level
		send_pixel(make_pixel(8'd255, 7'b1010101, 8'd128, 8'd128, 8'd128, 8'd128, LVL_NEAR));
		send_pixel(make_pixel(8'd0, 7'b0101010, 8'd0, 8'd0, 8'd0, 8'd0, LVL_NEAR));
		// vectors on the axes: exact angles 0, half, quarter, minus quarter
		send_pixel(make_pixel(8'd1, 7'b0011001, 8'd255, 8'd7, 8'd0, 8'd7, LVL_FAR));
		send_pixel(make_pixel(8'd254, 7'b1100110, 8'd0, 8'd7, 8'd255, 8'd7, LVL_NEAR));
		send_pixel(make_pixel(8'd128, 7'b0110011, 8'd9, 8'd0, 8'd9, 8'd255, LVL_ANY));
		send_pixel(make_pixel(8'd127, 7'b1001100, 8'd9, 8'd255, 8'd9, 8'd0, LVL_NEAR));
		// just off the +x axis: tiny positive angle, and one that rounds to <= 0
		send_pixel(make_pixel(8'd200, 7'b0000001, 8'd255, 8'd0, 8'd0, 8'd1, LVL_FAR));
		send_pixel(make_pixel(8'd60, 7'b1111111, 8'd255, 8'd1, 8'd0, 8'd0, LVL_ANY));
		// left half-plane near the -x axis, either side
		send_pixel(make_pixel(8'd90, 7'b0111000, 8'd0, 8'd0, 8'd255, 8'd1, LVL_NEAR));
		send_pixel(make_pixel(8'd33, 7'b0001110, 8'd0, 8'd1, 8'd255, 8'd0, LVL_ANY));
		// near the y axis, all four sides of it
		send_pixel(make_pixel(8'd170, 7'b1110000, 8'd1, 8'd0, 8'd0, 8'd255, LVL_ANY));
		send_pixel(make_pixel(8'd80, 7'b0100100, 8'd0, 8'd255, 8'd1, 8'd0, LVL_NEAR));
		send_pixel(make_pixel(8'd15, 7'b1011011, 8'd1, 8'd255, 8'd0, 8'd0, LVL_FAR));
		send_pixel(make_pixel(8'd240, 7'b0010010, 8'd0, 8'd0, 8'd1, 8'd255, LVL_ANY));
		// diagonals, full magnitude
		send_pixel(make_pixel(8'd100, 7'b1101101, 8'd255, 8'd0, 8'd0, 8'd255, LVL_ANY));
		send_pixel(make_pixel(8'd50, 7'b0110110, 8'd255, 8'd255, 8'd0, 8'd0, LVL_NEAR));
		send_pixel(make_pixel(8'd220, 7'b1000001, 8'd0, 8'd0, 8'd255, 8'd255, LVL_FAR));
		send_pixel(make_pixel(8'd5, 7'b0011100, 8'd0, 8'd255, 8'd255, 8'd0, LVL_ANY));
		// fringe order 0 in the last quarter: offset -1, negative result
		send_pixel(make_pixel(8'd180, 7'b0000000, 8'd40, 8'd200, 8'd40, 8'd10, LVL_ANY));
		// fringe order 64 (binary 127): largest offsets, both k2 and k2-1 branches
		send_pixel(make_pixel(8'd200, 7'b1000000, 8'd255, 8'd0, 8'd0, 8'd1, LVL_ANY));
		send_pixel(make_pixel(8'd200, 7'b1000000, 8'd70, 8'd255, 8'd70, 8'd0, LVL_ANY));
		// middle half: k1 branch at its top code
		send_pixel(make_pixel(8'd200, 7'b1000001, 8'd0, 8'd0, 8'd20, 8'd10, LVL_FAR));
		drain();

		// Random beats: no idling, idle source, stalling sink, both lightly.
		// Each mode ends with a full drain of the pipeline.
		for (int mode = 0; mode < 4; mode++) begin
			case (mode)
				0: begin src_gap_pct <= 0;  sink_hold_pct <= 0;  end
				1: begin src_gap_pct <= 67; sink_hold_pct <= 0;  end
				2: begin src_gap_pct <= 0;  sink_hold_pct <= 67; end
				default: begin src_gap_pct <= 9; sink_hold_pct <= 9; end
			endcase
			repeat (MODE_BEATS)
				send_pixel(random_pixel());
			drain();
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && phases_owed == 0)
			$display("gray_code_phase_shift_unwrap test passed");
		else
			$display("gray_code_phase_shift_unwrap test failed");
		$finish;
	end

endmodule

@@ gray_code_phase_shift_unwrap.f @@
hw/rtl/gcpsu_pkg.sv
hw/rtl/gcpsu_cordic.sv
hw/rtl/gray_code_phase_shift_unwrap.sv
sim/phase_checker.sv
sim/gray_code_phase_shift_unwrap_tb.sv
